// ===== rtl/lmf_pkg.sv =====
// shared types and constants of the label majority filter
package lmf_pkg;

  // fixed field and register widths
  localparam int unsigned LABEL_W     = 8;
  localparam int unsigned WIDTH_CFG_W = 11;
  localparam int unsigned HEIGHT_W    = 12;
  localparam int unsigned ROW_W       = 13;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 12;

  // register reset values
  localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 12'd480;

  // command code of a flush transaction
  localparam logic CMD_FLUSH = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ZERO_BORDER  = 2'd2
  } lmf_reg_e;

  // input transaction
  typedef struct packed {
    logic               cmd;
    logic [LABEL_W-1:0] pixel_label;
  } lmf_in_t;

  // output transaction
  typedef struct packed {
    logic [LABEL_W-1:0] out_label;
    logic               frame_last;
  } lmf_out_t;

  // per-item classification handed from front to back
  typedef struct packed {
    logic emit;
    logic interior;
    logic zero_border;
    logic frame_last;
  } lmf_flags_t;

endpackage

// ===== rtl/lmf_ram.sv =====
// generic single-write, single-read ram with registered read data
module lmf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and read-first registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lmf_fifo.sv =====
// small register queue between the front and back of the filter
module lmf_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNTW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    case ({push, pop})
      2'b10:   count_d = count_q + CNTW'(1);
      2'b01:   count_d = count_q - CNTW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/lmf_front.sv =====
// front end: raster position tracking, geometry latch and item classification
module lmf_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned LABEL_BITS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  lmf_pkg::lmf_in_t                      in_data_i,
  input  logic [$clog2(MAX_WIDTH + 1)-1:0]      cfg_width_i,
  input  logic [lmf_pkg::HEIGHT_W-1:0]          cfg_height_i,
  input  logic                                  cfg_zero_border_i,
  output logic                                  push_valid_o,
  input  logic                                  push_ready_i,
  output logic [$clog2(MAX_WIDTH)-1:0]          push_col_o,
  output logic [LABEL_BITS-1:0]                 push_label_o,
  output lmf_pkg::lmf_flags_t                   push_flags_o
);

  import lmf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  logic [CW-1:0]       col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [WW-1:0]       lat_width_q;
  logic [HEIGHT_W-1:0] lat_height_q;
  logic                lat_zb_q;

  logic                at_start, in_frame, skip, accept;
  logic [WW-1:0]       cur_width, col_inc;
  logic [HEIGHT_W-1:0] cur_height;
  logic [ROW_W-1:0]    height_ext;
  logic                cur_zb;
  lmf_flags_t          flags;

  // geometry of the current frame, taken from the registers at its first item
  always_comb begin
    at_start   = (row_q == '0) && (col_q == '0);
    cur_width  = at_start ? cfg_width_i       : lat_width_q;
    cur_height = at_start ? cfg_height_i      : lat_height_q;
    cur_zb     = at_start ? cfg_zero_border_i : lat_zb_q;
    height_ext = ROW_W'(cur_height);
    in_frame   = (row_q < height_ext);
  end

  // classify the item at the current raster position
  always_comb begin
    skip           = in_frame && (in_data_i.cmd == CMD_FLUSH);
    flags.emit     = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));
    flags.interior = (col_q >= CW'(2)) && (row_q >= ROW_W'(2)) && in_frame;
    flags.zero_border = cur_zb;
    flags.frame_last  = flags.emit && (col_q == '0) && (row_q == height_ext + ROW_W'(1));
  end

  // next raster position
  always_comb begin
    col_inc = WW'(col_q) + WW'(1);
    col_d   = CW'(col_inc);
    row_d   = row_q;
    if (flags.frame_last) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc == cur_width) begin
      col_d = '0;
      row_d = row_q + ROW_W'(1);
    end
  end

  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = in_valid_i && !skip;
  assign push_col_o   = col_q;
  assign push_label_o = in_frame ? in_data_i.pixel_label[LABEL_BITS-1:0] : '0;
  assign push_flags_o = flags;

  // position counters and latched geometry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      lat_width_q  <= '0;
      lat_height_q <= '0;
      lat_zb_q     <= 1'b0;
    end else if (accept && !skip) begin
      col_q        <= col_d;
      row_q        <= row_d;
      lat_width_q  <= cur_width;
      lat_height_q <= cur_height;
      lat_zb_q     <= cur_zb;
    end
  end

endmodule

// ===== rtl/lmf_back.sv =====
// back end: line stores, 3x3 window, majority vote and output register
module lmf_back #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned LABEL_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         head_valid_i,
  output logic                         head_ready_o,
  input  logic [$clog2(MAX_WIDTH)-1:0] head_col_i,
  input  logic [LABEL_BITS-1:0]        head_label_i,
  input  lmf_pkg::lmf_flags_t          head_flags_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lmf_pkg::lmf_out_t            out_data_o
);

  import lmf_pkg::*;

  localparam int unsigned CW           = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned MAJORITY_MIN = 6;
  // window positions of the eight neighbours, centre left out
  localparam logic [3:0]  NB_IDX [8]   = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8};

  logic                  adv, pop;

  // read stage
  logic                  s1_valid_q;
  logic [CW-1:0]         s1_col_q;
  logic [LABEL_BITS-1:0] s1_cur_q;
  lmf_flags_t            s1_flags_q;

  // bypass of a write to the address being read in the same cycle
  logic                  fwd_q;
  logic [LABEL_BITS-1:0] fwd_prev_q, fwd_prev2_q;

  logic [LABEL_BITS-1:0] prev_rdata, prev2_rdata;
  logic [LABEL_BITS-1:0] above, above2;

  // window stage
  logic [LABEL_BITS-1:0] window_q [9];
  logic                  s2_valid_q, s2_interior_q, s2_zb_q, s2_last_q;

  // output register
  logic                  out_valid_q, out_last_q;
  logic [LABEL_BITS-1:0] out_label_q;

  logic [LABEL_BITS-1:0] nb [8];
  logic [CNT_W-1:0]      cnt [8];
  logic [LABEL_BITS-1:0] majority_label, result_label;

  // whole back end moves together when the output register can take data
  assign adv          = !out_valid_q || out_ready_i;
  assign head_ready_o = adv;
  assign pop          = adv && head_valid_i;

  assign above  = fwd_q ? fwd_prev_q  : prev_rdata;
  assign above2 = fwd_q ? fwd_prev2_q : prev2_rdata;

  // row above the current position
  lmf_ram #(
    .WIDTH(LABEL_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_ram_prev (
    .clk_i  (clk_i),
    .we_i   (adv && s1_valid_q),
    .waddr_i(s1_col_q),
    .wdata_i(s1_cur_q),
    .re_i   (pop),
    .raddr_i(head_col_i),
    .rdata_o(prev_rdata)
  );

  // row two above the current position
  lmf_ram #(
    .WIDTH(LABEL_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_ram_prev2 (
    .clk_i  (clk_i),
    .we_i   (adv && s1_valid_q),
    .waddr_i(s1_col_q),
    .wdata_i(above),
    .re_i   (pop),
    .raddr_i(head_col_i),
    .rdata_o(prev2_rdata)
  );

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= head_valid_i;
      fwd_q       <= pop && s1_valid_q && (head_col_i == s1_col_q);
      s2_valid_q  <= s1_valid_q && s1_flags_q.emit;
      out_valid_q <= s2_valid_q;
    end
  end

  // stage payload and window shift
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (pop) begin
        s1_col_q   <= head_col_i;
        s1_cur_q   <= head_label_i;
        s1_flags_q <= head_flags_i;
      end
      fwd_prev_q  <= s1_cur_q;
      fwd_prev2_q <= above;
      if (s1_valid_q) begin
        for (int i = 0; i < 3; i++) begin
          window_q[i*3]     <= window_q[i*3+1];
          window_q[i*3+1]   <= window_q[i*3+2];
        end
        window_q[2] <= above2;
        window_q[5] <= above;
        window_q[8] <= s1_cur_q;
      end
      s2_interior_q <= s1_flags_q.interior;
      s2_zb_q       <= s1_flags_q.zero_border;
      s2_last_q     <= s1_flags_q.frame_last;
      out_label_q   <= result_label;
      out_last_q    <= s2_last_q;
    end
  end

  // majority vote over the eight neighbours; only one label can reach the threshold
  always_comb begin
    majority_label = '0;
    for (int i = 0; i < 8; i++) begin
      nb[i] = window_q[NB_IDX[i]];
    end
    for (int i = 0; i < 8; i++) begin
      cnt[i] = '0;
      for (int j = 0; j < 8; j++) begin
        cnt[i] = cnt[i] + CNT_W'(nb[j] == nb[i]);
      end
      if (cnt[i] >= CNT_W'(MAJORITY_MIN)) begin
        majority_label = majority_label | nb[i];
      end
    end
  end

  // border pixels pass the centre label through, or zero
  always_comb begin
    result_label = s2_interior_q ? majority_label : window_q[4];
    if (!s2_interior_q && s2_zb_q) begin
      result_label = '0;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_data_o.out_label  = LABEL_W'(out_label_q);
  assign out_data_o.frame_last = out_last_q;

endmodule

// ===== rtl/label_majority_filter_3x3.sv =====
// top level of the 3x3 label majority filter
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_ready_o  in_data_i  (cmd, pixel_label)
//   out      output     out_valid_o/out_ready_i  out_data_o (out_label, frame_last)
//   cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// one transaction per cycle sustained while the output is not stalled; a result is valid once
// the transaction that completes its window has passed the queue, then the line store read,
// the window and the output register.
// results trail the input by width+1 raster positions; flush transactions drain the tail.
// reset clears control only; line stores need no clearing pass.
// a stalled output freezes the back end, the two-entry queue absorbs the front.
module label_majority_filter_3x3 #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned LABEL_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  lmf_pkg::lmf_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output lmf_pkg::lmf_out_t                  out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lmf_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [lmf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import lmf_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW = (WW > WIDTH_CFG_W) ? WW : WIDTH_CFG_W;
  localparam int unsigned FW   = $bits(lmf_flags_t);
  localparam int unsigned QW   = CW + LABEL_BITS + FW;

  logic [WIDTH_CFG_W-1:0] cfg_width_q;
  logic [HEIGHT_W-1:0]    cfg_height_q;
  logic                   cfg_zb_q;

  logic [CMPW-1:0]        width_ext;
  logic [WW-1:0]          eff_width;
  logic [HEIGHT_W-1:0]    eff_height;

  logic                   push_valid, push_ready;
  logic [CW-1:0]          push_col;
  logic [LABEL_BITS-1:0]  push_label;
  lmf_flags_t             push_flags;

  logic                   head_valid, head_ready;
  logic [QW-1:0]          head_data;
  logic [CW-1:0]          head_col;
  logic [LABEL_BITS-1:0]  head_label;
  lmf_flags_t             head_flags;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WIDTH_RESET;
      cfg_height_q <= HEIGHT_RESET;
      cfg_zb_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  cfg_width_q  <= cfg_data_i[WIDTH_CFG_W-1:0];
        REG_FRAME_HEIGHT: cfg_height_q <= cfg_data_i[HEIGHT_W-1:0];
        REG_ZERO_BORDER:  cfg_zb_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // width clamped to 1..MAX_WIDTH, height zero taken as one
  always_comb begin
    width_ext = CMPW'(cfg_width_q);
    if (width_ext == '0) begin
      eff_width = WW'(1);
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(width_ext);
    end
    eff_height = (cfg_height_q == '0) ? HEIGHT_W'(1) : cfg_height_q;
  end

  lmf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .LABEL_BITS(LABEL_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_data_i        (in_data_i),
    .cfg_width_i      (eff_width),
    .cfg_height_i     (eff_height),
    .cfg_zero_border_i(cfg_zb_q),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_col_o       (push_col),
    .push_label_o     (push_label),
    .push_flags_o     (push_flags)
  );

  lmf_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i ({push_col, push_label, push_flags}),
    .pop_valid_o (head_valid),
    .pop_ready_i (head_ready),
    .pop_data_o  (head_data)
  );

  // unpack the queue head
  assign head_col   = head_data[QW-1 -: CW];
  assign head_label = head_data[FW +: LABEL_BITS];
  assign head_flags = lmf_flags_t'(head_data[FW-1:0]);

  lmf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .LABEL_BITS(LABEL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_ready_o(head_ready),
    .head_col_i  (head_col),
    .head_label_i(head_label),
    .head_flags_i(head_flags),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  // the last pixel of a frame is always the right border pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid && head_flags.frame_last) |->
      (head_flags.emit && (head_col == '0) && !head_flags.interior))
    else $error("frame end item not at column zero");

  // an interior result needs a full window to the left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid && head_flags.interior) |-> (head_flags.emit && (head_col >= CW'(2))))
    else $error("interior item without full window");

  // a transaction dropped by the front is always a flush
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !push_valid) |-> (in_data_i.cmd == CMD_FLUSH))
    else $error("pixel transaction dropped by front");
`endif

endmodule
